// File: design/cross_min_filter_rgb_defines.svh
// assertion macros shared by the cross min filter rtl
`ifndef CROSS_MIN_FILTER_RGB_DEFINES_SVH
`define CROSS_MIN_FILTER_RGB_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked assertion, masked while reset is asserted
`define CMF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked assertion that also holds during reset
`define CMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMF_ASSERT(lbl, clk, rstn, prop, msg)
`define CMF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/cmf_pkg.sv
// shared types and constants of the cross min filter
package cmf_pkg;

    localparam int CHAN_BITS   = 8;
    localparam int CFG_W_BITS  = 11;
    localparam int CFG_H_BITS  = 12;
    localparam int CFG_D_BITS  = 12;
    localparam int CFG_I_BITS  = 1;

    // register indexes of the configuration port
    localparam logic [CFG_I_BITS-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_I_BITS-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_pixel;

    // one column of the line memory: row y-2 and row y-1
    typedef struct packed {
        t_pixel older;
        t_pixel prev;
    } t_line_entry;

endpackage

// File: design/cmf_line_mem.sv
// line memory holding the two previous rows, registered read
module cmf_line_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output cmf_pkg::t_line_entry         o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  cmf_pkg::t_line_entry         i_wr_data
);
    import cmf_pkg::*;

    t_line_entry r_mem [DEPTH];
    t_line_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/cmf_window.sv
// window taps and per channel five point minimum
module cmf_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  cmf_pkg::t_pixel       i_cur,
    input  cmf_pkg::t_line_entry  i_line,
    output cmf_pkg::t_pixel       o_min
);
    import cmf_pkg::*;

    t_pixel r_mid_centre;
    t_pixel r_mid_left;
    t_pixel r_top;
    t_pixel r_bottom;

    function automatic logic [CHAN_BITS-1:0] min5(
        input logic [CHAN_BITS-1:0] a,
        input logic [CHAN_BITS-1:0] b,
        input logic [CHAN_BITS-1:0] c,
        input logic [CHAN_BITS-1:0] d,
        input logic [CHAN_BITS-1:0] e
    );
        logic [CHAN_BITS-1:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        if (d < m) m = d;
        if (e < m) m = e;
        return m;
    endfunction

    always_comb begin
        o_min.red   = min5(r_mid_centre.red, i_line.prev.red, r_mid_left.red,
                           r_bottom.red, r_top.red);
        o_min.green = min5(r_mid_centre.green, i_line.prev.green, r_mid_left.green,
                           r_bottom.green, r_top.green);
        o_min.blue  = min5(r_mid_centre.blue, i_line.prev.blue, r_mid_left.blue,
                           r_bottom.blue, r_top.blue);
    end

    // taps shift one column per processed pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_centre <= '0;
            r_mid_left   <= '0;
            r_top        <= '0;
            r_bottom     <= '0;
        end else if (i_advance) begin
            r_mid_centre <= i_line.prev;
            r_mid_left   <= r_mid_centre;
            r_top        <= i_line.older;
            r_bottom     <= i_cur;
        end
    end

endmodule

// File: design/cross_min_filter_rgb.sv
// top level of the rgb cross min filter (5 point erosion)
// Takes RGB pixels in raster order and, for every interior pixel, returns the
// per-channel minimum over that pixel and its left, right, upper and lower
// neighbors. The result for center (x-1,y-1) comes out after pixel (x,y) with
// x>=2 and y>=2 has been taken; border pixels produce no result, and
// o_frame_end marks the last result of a frame. One pixel is accepted per
// clock as long as the result side keeps taking; an accepted pixel is held in
// stage 1 and its result is then loaded into the output register. Stage 1 is
// there for the line memory: its read is registered, and the same column is
// written back with the shifted rows when stage 1 moves on. Writing either
// frame-size register starts a new frame with the next pixel; write only while
// the block is idle. The line memory needs no clearing after reset, every
// entry that feeds a result is written earlier in the same frame.
`include "cross_min_filter_rgb_defines.svh"

module cross_min_filter_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel request in
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cmf_pkg::CHAN_BITS-1:0]       i_in_red,
    input  logic [cmf_pkg::CHAN_BITS-1:0]       i_in_green,
    input  logic [cmf_pkg::CHAN_BITS-1:0]       i_in_blue,
    // result request out
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cmf_pkg::CHAN_BITS-1:0]       o_out_red,
    output logic [cmf_pkg::CHAN_BITS-1:0]       o_out_green,
    output logic [cmf_pkg::CHAN_BITS-1:0]       o_out_blue,
    output logic                                o_frame_end,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [cmf_pkg::CFG_I_BITS-1:0]      i_cfg_index,
    input  logic [cmf_pkg::CFG_D_BITS-1:0]      i_cfg_data
);
    import cmf_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    // compare width wide enough for both the register and MAX_WIDTH itself
    localparam int WCMP = (CFG_W_BITS > XW + 1) ? CFG_W_BITS : XW + 1;

    // frame size registers
    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;

    // raster position of the next accepted pixel
    logic [XW-1:0]         r_col;
    logic [CFG_H_BITS-1:0] r_row;
    logic [XW-1:0]         n_col;
    logic [CFG_H_BITS-1:0] n_row;

    // effective last column and last row
    logic [WCMP-1:0]       width_ext;
    logic [WCMP-1:0]       last_col_ext;
    logic [XW-1:0]         last_col;
    logic [CFG_H_BITS-1:0] last_row;
    logic                  at_row_end;
    logic                  at_frame_end;

    // stage 1: line memory read in flight
    logic                  r_s1_valid;
    logic [XW-1:0]         r_s1_addr;
    t_pixel                r_s1_pix;
    logic                  r_s1_has_result;
    logic                  r_s1_frame_end;

    // output register
    logic                  r_out_valid;
    t_pixel                r_out_pix;
    logic                  r_out_frame_end;

    logic                  in_accept;
    logic                  out_free;
    logic                  s1_fire;
    t_pixel                in_pix;
    t_pixel                win_min;
    t_line_entry           mem_rd_data;
    t_line_entry           mem_wr_data;

    // ---------------------------------------------------------------
    // frame geometry: width clamped to 3..MAX_WIDTH, height raised to 3
    // ---------------------------------------------------------------
    assign width_ext = WCMP'(r_width);

    always_comb begin
        if (width_ext < WCMP'(3)) begin
            last_col_ext = WCMP'(2);
        end else if (width_ext > WCMP'(MAX_WIDTH)) begin
            last_col_ext = WCMP'(MAX_WIDTH - 1);
        end else begin
            last_col_ext = width_ext - WCMP'(1);
        end
    end

    assign last_col     = last_col_ext[XW-1:0];
    assign last_row     = (r_height < CFG_H_BITS'(3)) ? CFG_H_BITS'(2)
                                                      : r_height - CFG_H_BITS'(1);
    assign at_row_end   = (r_col == last_col);
    assign at_frame_end = at_row_end && (r_row == last_row);

    // ---------------------------------------------------------------
    // handshake: stage 1 moves on when the output register has room
    // ---------------------------------------------------------------
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_accept  = i_in_valid && o_in_ready;

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W_BITS'(640);
            r_height <= CFG_H_BITS'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // raster counters, wrap at row and frame end
    // ---------------------------------------------------------------
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            // any size write starts a fresh frame
            n_col = '0;
            n_row = '0;
        end else if (in_accept) begin
            if (at_row_end) begin
                n_col = '0;
                n_row = (r_row == last_row) ? '0 : r_row + CFG_H_BITS'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------
    // stage 1 holds the pixel while the column is read
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr       <= r_col;
            r_s1_pix        <= in_pix;
            r_s1_has_result <= (r_col >= XW'(2)) && (r_row >= CFG_H_BITS'(2));
            r_s1_frame_end  <= at_frame_end;
        end
    end

    // ---------------------------------------------------------------
    // line memory: read at accept, rows shifted and written back at fire
    // ---------------------------------------------------------------
    assign mem_wr_data.older = mem_rd_data.prev;
    assign mem_wr_data.prev  = r_s1_pix;

    cmf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (mem_wr_data)
    );

    cmf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_fire),
        .i_cur     (r_s1_pix),
        .i_line    (mem_rd_data),
        .o_min     (win_min)
    );

    // ---------------------------------------------------------------
    // output register, loaded only for interior pixels
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_has_result) begin
            r_out_pix       <= win_min;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix.red;
    assign o_out_green = r_out_pix.green;
    assign o_out_blue  = r_out_pix.blue;
    assign o_frame_end = r_out_frame_end;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // write-back never lands on the column being read
    `CMF_ASSERT(a_no_rw_collision, i_clk, i_rst_n, (in_accept && s1_fire) |-> (r_col != r_s1_addr), "line memory read and write hit the same column")
    // input only stalls behind a blocked output
    `CMF_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready), "input stalled without a full pipeline")
    // column counter stays inside the frame
    `CMF_ASSERT(a_col_bound, i_clk, i_rst_n, r_col <= last_col, "column counter past last column")
    // last pixel of a frame wraps both counters
    `CMF_ASSERT(a_frame_wrap, i_clk, i_rst_n, (in_accept && at_frame_end) |=> (r_col == '0 && r_row == '0), "counters did not wrap at frame end")

endmodule
